// ===== rtl/qenc_pkg.sv =====
// ----------------------------------------------------------------------------
// qenc_pkg
// Constants and the quadrature transition table for the encoder and switch
// decoder.
// ----------------------------------------------------------------------------
package qenc_pkg;

  localparam int unsigned CountW    = 32;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 20;
  localparam int unsigned AccW      = 4;
  localparam int unsigned StepW     = 2;

  localparam logic [1:0]            PINS_REST      = 2'b11;
  localparam logic [DebounceW-1:0]  DEBOUNCE_RESET = 20'd20000;
  localparam logic signed [AccW:0]  ACC_MAX        = 5'sd7;
  localparam logic signed [AccW:0]  ACC_MIN        = -5'sd8;
  localparam logic signed [AccW-1:0] DETENT_QUARTERS = 4'sd4;

  localparam logic signed [StepW-1:0] STEP_NONE = 2'sd0;
  localparam logic signed [StepW-1:0] STEP_UP   = 2'sd1;
  localparam logic signed [StepW-1:0] STEP_DOWN = -2'sd1;

  localparam logic CMD_ENCODER = 1'b0;
  localparam logic CMD_SWITCH  = 1'b1;

  // Index: previous pair in bits 3:2, new pair in bits 1:0
  localparam logic signed [1:0] STEP_LUT [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

endpackage

// ===== rtl/quadrature_encoder_with_switch_debounce.sv =====
// A request is either an encoder pin change (cmd_i low) or a switch edge
// (cmd_i high) and yields exactly one result. The block takes one request
// per clock cycle unless in_stall_o is high; each request is held in the
// input register and is then decoded against the encoder and switch state
// into the result register, and an empty input register can take a new
// request while a result waits. The debounce time is to be written by the
// user through cfg_we_i/cfg_wdata_i while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
// quadrature_encoder_with_switch_debounce
// Quadrature detent counter with a debounced push switch press detector.
// ----------------------------------------------------------------------------
module quadrature_encoder_with_switch_debounce (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [qenc_pkg::DebounceW-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  cmd_i,
  input  logic                                  pin_a_i,
  input  logic                                  pin_b_i,
  input  logic                                  falling_edge_i,
  input  logic [qenc_pkg::TimeW-1:0]            now_us_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [qenc_pkg::CountW-1:0]    position_count_o,
  output logic signed [qenc_pkg::StepW-1:0]     step_o,
  output logic                                  press_event_o
);
  import qenc_pkg::*;

  logic                    debounce_en;
  logic [DebounceW-1:0]    debounce_q;

  logic                    req_valid_q;
  logic                    req_cmd_q;
  logic [1:0]              req_pins_q;
  logic                    req_falling_q;
  logic [TimeW-1:0]        req_now_q;

  logic [1:0]              last_pins_q, last_pins_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [TimeW-1:0]        edge_time_q, edge_time_d;

  logic                    res_valid_q;
  logic [CountW-1:0]       res_count_q;
  logic signed [StepW-1:0] res_step_q, step_d;
  logic                    res_press_q, press_d;

  logic                    req_move;
  logic                    req_load;
  logic signed [AccW:0]    acc_sum;
  logic signed [AccW-1:0]  acc_sat;
  logic [TimeW-1:0]        elapsed;

  assign debounce_en = cfg_we_i;
  assign req_move    = req_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o  = req_valid_q && !req_move;
  assign req_load    = in_valid_i && !in_stall_o;

  always_comb begin
    last_pins_d = last_pins_q;
    acc_d       = acc_q;
    count_d     = count_q;
    edge_time_d = edge_time_q;
    step_d      = STEP_NONE;
    press_d     = 1'b0;
    acc_sum     = '0;
    acc_sat     = '0;
    elapsed     = req_now_q - edge_time_q;
    case (req_cmd_q)
      CMD_ENCODER: begin
        acc_sum = {acc_q[AccW-1], acc_q}
                + (AccW+1)'(STEP_LUT[{last_pins_q, req_pins_q}]);
        if (acc_sum > ACC_MAX) begin
          acc_sat = ACC_MAX[AccW-1:0];
        end else if (acc_sum < ACC_MIN) begin
          acc_sat = ACC_MIN[AccW-1:0];
        end else begin
          acc_sat = acc_sum[AccW-1:0];
        end
        acc_d       = acc_sat;
        last_pins_d = req_pins_q;
        if (req_pins_q == PINS_REST) begin
          if (acc_sat >= DETENT_QUARTERS) begin
            count_d = count_q + CountW'(1);
            step_d  = STEP_UP;
          end else if (acc_sat <= -DETENT_QUARTERS) begin
            count_d = count_q - CountW'(1);
            step_d  = STEP_DOWN;
          end
          acc_d = '0;
        end
      end
      CMD_SWITCH: begin
        press_d     = req_falling_q && (elapsed > TimeW'(debounce_q));
        edge_time_d = req_now_q;
      end
      default: begin
        step_d = STEP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DEBOUNCE_RESET;
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      last_pins_q <= PINS_REST;
      acc_q       <= '0;
      count_q     <= '0;
      edge_time_q <= '0;
    end else begin
      if (debounce_en) begin
        debounce_q <= cfg_wdata_i;
      end
      if (req_load) begin
        req_valid_q <= 1'b1;
      end else if (req_move) begin
        req_valid_q <= 1'b0;
      end
      if (req_move) begin
        res_valid_q <= 1'b1;
        last_pins_q <= last_pins_d;
        acc_q       <= acc_d;
        count_q     <= count_d;
        edge_time_q <= edge_time_d;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_load) begin
      req_cmd_q     <= cmd_i;
      req_pins_q    <= {pin_a_i, pin_b_i};
      req_falling_q <= falling_edge_i;
      req_now_q     <= now_us_i;
    end
    if (req_move) begin
      res_count_q <= count_d;
      res_step_q  <= step_d;
      res_press_q <= press_d;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign position_count_o = signed'(res_count_q);
  assign step_o           = res_step_q;
  assign press_event_o    = res_press_q;

  a_rest_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_pins_q == PINS_REST |-> acc_q == '0)
    else $error("accumulator not clear at rest position");

  a_press_or_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && press_event_o |-> step_o == STEP_NONE)
    else $error("press and step in one result");

  a_step_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> step_o != 2'b10)
    else $error("invalid step code");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_move |=> res_count_q == count_q)
    else $error("result count differs from detent count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_load && req_valid_q |-> req_move)
    else $error("input register overwritten");

endmodule
